// File: design/bf3_pkg.sv
// Shared types and constants for the 3x3 bilateral filter.
// No dependencies; imported by bf3_div and bilateral_filter_3x3_top.
package bf3_pkg;

  localparam int PIX_W   = 8;
  localparam int COORD_W = 10;
  localparam int NB_CNT  = 8;

  // config register map, word index = paddr[3:2]
  typedef enum logic [1:0] {
    REG_LINE_WIDTH    = 2'd0,
    REG_FRAME_HEIGHT  = 2'd1,
    REG_EDGE_WEIGHT   = 2'd2,
    REG_CORNER_WEIGHT = 2'd3
  } reg_idx_e;

  localparam logic [10:0] LINE_WIDTH_RST    = 11'd1024;
  localparam logic [10:0] FRAME_HEIGHT_RST  = 11'd1024;
  localparam logic [15:0] EDGE_WEIGHT_RST   = 16'd39750;
  localparam logic [15:0] CORNER_WEIGHT_RST = 16'd24109;
  localparam logic [10:0] DIM_MIN           = 11'd3;

  // position of a filtered pixel, carried alongside the datapath
  typedef struct packed {
    logic [COORD_W-1:0] row;
    logic [COORD_W-1:0] col;
    logic               done;
  } bf3_meta_t;

endpackage

// File: design/bf3_div.sv
// Pipelined restoring divider, one quotient bit per stage, 8-bit quotient.
// Depends on bf3_pkg (PIX_W, bf3_meta_t).
module bf3_div import bf3_pkg::*; #(
  parameter int NUM_W = 32,
  parameter int DEN_W = 24
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             in_valid_i,
  output logic             in_ready_o,
  input  logic [NUM_W-1:0] num_i,
  input  logic [DEN_W-1:0] den_i,
  input  bf3_meta_t        meta_i,
  output logic             out_valid_o,
  input  logic             out_ready_i,
  output logic [PIX_W-1:0] quot_o,
  output bf3_meta_t        meta_o
);

  logic [PIX_W-1:0] v_q;
  logic [NUM_W-1:0] rem_q  [PIX_W];
  logic [DEN_W-1:0] den_q  [PIX_W];
  logic [PIX_W-1:0] quo_q  [PIX_W];
  bf3_meta_t        meta_q [PIX_W];
  logic [PIX_W:0]   rdy;

  assign rdy[PIX_W] = out_ready_i;

  for (genvar k = 0; k < PIX_W; k++) begin : g_stage
    localparam int BIT = PIX_W - 1 - k;
    logic             v_in;
    logic [NUM_W-1:0] rem_in;
    logic [DEN_W-1:0] den_in;
    logic [PIX_W-1:0] quo_in;
    bf3_meta_t        meta_in;
    logic [NUM_W-1:0] shd;
    logic             ge;

    if (k == 0) begin : g_first
      assign v_in    = in_valid_i;
      assign rem_in  = num_i;
      assign den_in  = den_i;
      assign quo_in  = '0;
      assign meta_in = meta_i;
    end else begin : g_next
      assign v_in    = v_q[k-1];
      assign rem_in  = rem_q[k-1];
      assign den_in  = den_q[k-1];
      assign quo_in  = quo_q[k-1];
      assign meta_in = meta_q[k-1];
    end

    assign rdy[k] = !v_q[k] || rdy[k+1];
    assign shd    = NUM_W'(den_in) << BIT;
    assign ge     = rem_in >= shd;

    always_ff @(posedge clk_i or negedge rst_ni) begin
      if (!rst_ni) begin
        v_q[k] <= 1'b0;
      end else if (rdy[k]) begin
        v_q[k] <= v_in;
      end
    end

    always_ff @(posedge clk_i) begin
      if (rdy[k]) begin
        rem_q[k]  <= ge ? (rem_in - shd) : rem_in;
        den_q[k]  <= den_in;
        quo_q[k]  <= quo_in | (PIX_W'(ge) << BIT);
        meta_q[k] <= meta_in;
      end
    end
  end

  assign in_ready_o  = rdy[0];
  assign out_valid_o = v_q[PIX_W-1];
  assign quot_o      = quo_q[PIX_W-1];
  assign meta_o      = meta_q[PIX_W-1];

endmodule

// File: design/bilateral_filter_3x3_top.sv
// Top level of the streaming 3x3 bilateral filter, APB register port.
// Depends on bf3_pkg and bf3_div.
//
// One 8-bit pixel (func=0) or one range-table load (func=1) is taken per word,
// one word per clock when the output side keeps up. Pixels arrive in raster
// order; two line stores (MAX_WIDTH x 8, single write and single registered
// read each) feed a 3x3 window. For every interior position one filtered pixel
// leaves, tagged with its row, column and a frame_done flag on the last one of
// the frame; border positions give nothing. The stages in order are line store
// read, window, range lookup, spatial x range multiply, weight x pixel
// multiply, accumulate, then 8 divider stages (one quotient bit each). The
// range table is held as eight identical 256 x 16 copies, one per neighbour,
// so all eight lookups happen in the same cycle; a table load is written in the
// lookup stage, in order with the pixels around it. Each stage holds its word
// on a stall and takes a new one when the next stage has room, so nothing is
// lost or repeated. Writing the row length or frame height register restarts
// the frame; registers should be written only with the pipeline empty.
module bilateral_filter_3x3_top import bf3_pkg::*; #(
  parameter int MAX_WIDTH        = 1024,
  parameter int MAX_HEIGHT       = 1024,
  parameter int WEIGHT_FRAC_BITS = 16
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  // APB register port
  input  logic                psel,
  input  logic                penable,
  input  logic                pwrite,
  input  logic [3:0]          paddr,
  input  logic [31:0]         pwdata,
  output logic [31:0]         prdata,
  output logic                pready,
  // input words
  input  logic                in_valid_i,
  output logic                in_ready_o,
  input  logic                func_i,
  input  logic [PIX_W-1:0]    pixel_i,
  input  logic [7:0]          weight_index_i,
  input  logic [15:0]         weight_value_i,
  // result words
  output logic                out_valid_o,
  input  logic                out_ready_i,
  output logic [PIX_W-1:0]    out_pixel_o,
  output logic [COORD_W-1:0]  out_row_o,
  output logic [COORD_W-1:0]  out_col_o,
  output logic                frame_done_o
);

  localparam int F    = WEIGHT_FRAC_BITS;
  localparam int CW   = $clog2(MAX_WIDTH);
  localparam int RW   = $clog2(MAX_HEIGHT);
  localparam int MXW  = (CW > RW) ? CW : RW;
  localparam int XW   = ((MXW > 11) ? MXW : 11) + 1;
  localparam int PW   = 32 - F;                       // neighbour weight width
  localparam int MW   = (F > PW) ? F : PW;
  localparam int WW   = MW + 4;                       // weight sum width
  localparam int AW   = WW + PIX_W;                   // accumulator width
  localparam int WPW  = PW + PIX_W;                   // weight x pixel width

  // ---------------------------------------------------------------------------
  // Configuration registers
  // ---------------------------------------------------------------------------
  logic [10:0] lw_q, fh_q;
  logic [15:0] edge_w_q, corner_w_q;
  logic        cfg_wr;
  reg_idx_e    cfg_idx;
  logic [10:0] dim_in;
  logic [10:0] lw_sat, fh_sat;

  assign pready  = 1'b1;
  assign cfg_wr  = psel && penable && pwrite;
  assign cfg_idx = reg_idx_e'(paddr[3:2]);
  assign dim_in  = pwdata[10:0];

  // clamp dimensions to 3..MAX
  always_comb begin
    lw_sat = dim_in;
    if (dim_in < DIM_MIN) lw_sat = DIM_MIN;
    else if (32'(dim_in) > MAX_WIDTH) lw_sat = 11'(MAX_WIDTH);
    fh_sat = dim_in;
    if (dim_in < DIM_MIN) fh_sat = DIM_MIN;
    else if (32'(dim_in) > MAX_HEIGHT) fh_sat = 11'(MAX_HEIGHT);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      lw_q       <= LINE_WIDTH_RST;
      fh_q       <= FRAME_HEIGHT_RST;
      edge_w_q   <= EDGE_WEIGHT_RST;
      corner_w_q <= CORNER_WEIGHT_RST;
    end else if (cfg_wr) begin
      case (cfg_idx)
        REG_LINE_WIDTH:    lw_q       <= lw_sat;
        REG_FRAME_HEIGHT:  fh_q       <= fh_sat;
        REG_EDGE_WEIGHT:   edge_w_q   <= pwdata[15:0];
        REG_CORNER_WEIGHT: corner_w_q <= pwdata[15:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    case (cfg_idx)
      REG_LINE_WIDTH:    prdata = 32'(lw_q);
      REG_FRAME_HEIGHT:  prdata = 32'(fh_q);
      REG_EDGE_WEIGHT:   prdata = 32'(edge_w_q);
      REG_CORNER_WEIGHT: prdata = 32'(corner_w_q);
      default:           prdata = '0;
    endcase
  end

  // ---------------------------------------------------------------------------
  // Stage handshake: a stage loads when it is empty or its word moves on
  // ---------------------------------------------------------------------------
  logic v1_q, v2_q, v3_q, v4_q, v5_q, v6_q;
  logic r1, r2, r3, r4, r5, r6;
  logic div_ready;
  logic accept;

  assign r6 = !v6_q || div_ready;
  assign r5 = !v5_q || r6;
  assign r4 = !v4_q || r5;
  assign r3 = !v3_q || r4;
  assign r2 = !v2_q || r3;
  assign r1 = !v1_q || r2;

  assign in_ready_o = r1;
  assign accept     = in_valid_i && r1;

  // ---------------------------------------------------------------------------
  // Position counters, updated as pixel words are taken
  // ---------------------------------------------------------------------------
  logic [CW-1:0] col_q;
  logic [RW-1:0] row_q;
  logic [XW-1:0] c_x, r_x, lw_x, fh_x;
  logic          emit_d;
  bf3_meta_t     meta_d;

  assign c_x    = XW'(col_q);
  assign r_x    = XW'(row_q);
  assign lw_x   = XW'(lw_q);
  assign fh_x   = XW'(fh_q);
  assign emit_d = (r_x >= XW'(2)) && (c_x >= XW'(2)) && !func_i;

  always_comb begin
    logic [XW-1:0] rm1, cm1;
    rm1         = r_x - XW'(1);
    cm1         = c_x - XW'(1);
    meta_d.row  = rm1[COORD_W-1:0];
    meta_d.col  = cm1[COORD_W-1:0];
    meta_d.done = (r_x + XW'(1) == fh_x) && (c_x + XW'(1) == lw_x);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      col_q <= '0;
      row_q <= '0;
    end else if (cfg_wr && (cfg_idx == REG_LINE_WIDTH || cfg_idx == REG_FRAME_HEIGHT)) begin
      col_q <= '0;
      row_q <= '0;
    end else if (accept && !func_i) begin
      if (c_x + XW'(1) >= lw_x) begin
        col_q <= '0;
        row_q <= (r_x + XW'(1) >= fh_x) ? '0 : RW'(r_x + XW'(1));
      end else begin
        col_q <= CW'(c_x + XW'(1));
      end
    end
  end

  // ---------------------------------------------------------------------------
  // Stage 1: line store read
  // ---------------------------------------------------------------------------
  logic [PIX_W-1:0] line_a_q [MAX_WIDTH];   // row above
  logic [PIX_W-1:0] line_b_q [MAX_WIDTH];   // two rows above
  logic [PIX_W-1:0] top1_q, mid1_q, px1_q;
  logic [CW-1:0]    col1_q;
  logic             func1_q, emit1_q;
  logic [7:0]       widx1_q;
  logic [15:0]      wval1_q;
  bf3_meta_t        meta1_q;
  logic             ls_wr;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) v1_q <= 1'b0;
    else if (r1) v1_q <= in_valid_i;
  end

  always_ff @(posedge clk_i) begin
    if (r1) begin
      px1_q   <= pixel_i;
      col1_q  <= col_q;
      func1_q <= func_i;
      emit1_q <= emit_d;
      widx1_q <= weight_index_i;
      wval1_q <= weight_value_i;
      meta1_q <= meta_d;
    end
    if (accept) begin
      top1_q <= line_b_q[col_q];
      mid1_q <= line_a_q[col_q];
    end
  end

  // stores move on when the pixel leaves stage 1
  assign ls_wr = v1_q && r2 && !func1_q;

  always_ff @(posedge clk_i) begin
    if (ls_wr) begin
      line_b_q[col1_q] <= mid1_q;
      line_a_q[col1_q] <= px1_q;
    end
  end

  // ---------------------------------------------------------------------------
  // Stage 2: window shift and range table addressing
  // ---------------------------------------------------------------------------
  logic [PIX_W-1:0] win_q  [9];
  logic [PIX_W-1:0] win_d  [9];
  logic [PIX_W-1:0] pix2_q [9];
  logic             func2_q, emit2_q;
  logic [7:0]       widx2_q;
  logic [15:0]      wval2_q;
  bf3_meta_t        meta2_q;

  always_comb begin
    for (int rr = 0; rr < 3; rr++) begin
      win_d[rr*3]   = win_q[rr*3+1];
      win_d[rr*3+1] = win_q[rr*3+2];
    end
    win_d[2] = top1_q;
    win_d[5] = mid1_q;
    win_d[8] = px1_q;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int i = 0; i < 9; i++) win_q[i] <= '0;
    end else if (ls_wr) begin
      win_q <= win_d;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) v2_q <= 1'b0;
    else if (r2) v2_q <= v1_q;
  end

  always_ff @(posedge clk_i) begin
    if (r2) begin
      pix2_q  <= win_d;
      func2_q <= func1_q;
      emit2_q <= emit1_q;
      widx2_q <= widx1_q;
      wval2_q <= wval1_q;
      meta2_q <= meta1_q;
    end
  end

  // ---------------------------------------------------------------------------
  // Stages 3 and 4: range weights (registered table read), spatial products
  // ---------------------------------------------------------------------------
  logic             rt_wr;
  logic [15:0]      rw3_q  [NB_CNT];
  logic [PIX_W-1:0] pix3_q [9];
  bf3_meta_t        meta3_q;
  logic [PW-1:0]    w4_q   [NB_CNT];
  logic [PIX_W-1:0] pix4_q [9];
  bf3_meta_t        meta4_q;

  assign rt_wr = v2_q && r3 && func2_q;

  for (genvar j = 0; j < NB_CNT; j++) begin : g_nb
    localparam int P = (j < 4) ? j : j + 1;
    logic [15:0]      rt_q [256];
    logic [PIX_W-1:0] diff;
    logic [15:0]      spatial;
    logic [31:0]      prod;

    assign diff = (pix2_q[P] > pix2_q[4]) ? (pix2_q[P] - pix2_q[4])
                                          : (pix2_q[4] - pix2_q[P]);

    always_ff @(posedge clk_i) begin
      if (rt_wr) rt_q[widx2_q] <= wval2_q;
      if (r3)    rw3_q[j]      <= rt_q[diff];
    end

    // edge neighbours sit at odd window positions
    assign spatial = (P % 2 == 1) ? edge_w_q : corner_w_q;
    assign prod    = 32'(spatial) * 32'(rw3_q[j]);

    always_ff @(posedge clk_i) begin
      if (r4) w4_q[j] <= prod[31:F];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v3_q <= 1'b0;
      v4_q <= 1'b0;
    end else begin
      if (r3) v3_q <= v2_q && emit2_q;
      if (r4) v4_q <= v3_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (r3) begin
      pix3_q  <= pix2_q;
      meta3_q <= meta2_q;
    end
    if (r4) begin
      pix4_q  <= pix3_q;
      meta4_q <= meta3_q;
    end
  end

  // ---------------------------------------------------------------------------
  // Stage 5: weight sum and weight x pixel products
  // ---------------------------------------------------------------------------
  logic [WPW-1:0]   wp5_q [NB_CNT];
  logic [WW-1:0]    wsum5_q, wsum_d;
  logic [PIX_W-1:0] ctr5_q;
  bf3_meta_t        meta5_q;

  always_comb begin
    wsum_d = WW'(1) << F;
    for (int j = 0; j < NB_CNT; j++) wsum_d = wsum_d + WW'(w4_q[j]);
  end

  always_ff @(posedge clk_i) begin
    if (r5) begin
      for (int j = 0; j < NB_CNT; j++) begin
        wp5_q[j] <= WPW'(w4_q[j]) * WPW'(pix4_q[(j < 4) ? j : j + 1]);
      end
      wsum5_q <= wsum_d;
      ctr5_q  <= pix4_q[4];
      meta5_q <= meta4_q;
    end
  end

  // ---------------------------------------------------------------------------
  // Stage 6: accumulate numerator
  // ---------------------------------------------------------------------------
  logic [AW-1:0] acc_d, acc6_q;
  logic [WW-1:0] wsum6_q;
  bf3_meta_t     meta6_q;

  always_comb begin
    acc_d = AW'(ctr5_q) << F;
    for (int j = 0; j < NB_CNT; j++) acc_d = acc_d + AW'(wp5_q[j]);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v5_q <= 1'b0;
      v6_q <= 1'b0;
    end else begin
      if (r5) v5_q <= v4_q;
      if (r6) v6_q <= v5_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (r6) begin
      acc6_q  <= acc_d;
      wsum6_q <= wsum5_q;
      meta6_q <= meta5_q;
    end
  end

  // ---------------------------------------------------------------------------
  // Divider; weighted mean never exceeds 255, so the 8-bit quotient is final
  // ---------------------------------------------------------------------------
  bf3_meta_t out_meta;

  bf3_div #(
    .NUM_W (AW),
    .DEN_W (WW)
  ) u_div (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (v6_q),
    .in_ready_o  (div_ready),
    .num_i       (acc6_q),
    .den_i       (wsum6_q),
    .meta_i      (meta6_q),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .quot_o      (out_pixel_o),
    .meta_o      (out_meta)
  );

  assign out_row_o    = out_meta.row;
  assign out_col_o    = out_meta.col;
  assign frame_done_o = out_meta.done;

  // ---------------------------------------------------------------------------
  // Assertions
  // ---------------------------------------------------------------------------
  a_load_no_result: assert property (@(posedge clk_i) disable iff (!rst_ni)
    v1_q && func1_q |-> !emit1_q)
    else $error("range load word marked to give a result");

  a_s1_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    v1_q && !r2 |=> v1_q && $stable(px1_q) && $stable(col1_q))
    else $error("stage 1 word lost while stalled");

  a_win_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    v1_q && !r2 |=> $stable(win_q[4]) && $stable(win_q[8]))
    else $error("window shifted during a stall");

  a_table_order: assert property (@(posedge clk_i) disable iff (!rst_ni)
    rt_wr |-> !emit2_q)
    else $error("table load and pixel lookup in the same word");

endmodule
